### src/acf_pkg.sv
package acf_pkg;

    // Address limits of the claim procedure.
    localparam logic [7:0] LAST_ADDRESS         = 8'd252;
    localparam logic [7:0] CANNOT_CLAIM_ADDRESS = 8'd254;
    localparam logic [7:0] GLOBAL_ADDRESS       = 8'd255;

    // Identifier patterns, already cut to the 29 identifier bits.
    localparam logic [28:0] CLAIM_MATCH   = 29'h18eeff00;
    localparam logic [28:0] REQUEST_MATCH = 29'h18ea0000;

    // Parameter group numbers carried in the low 24 bits of a request.
    localparam logic [23:0] PGN_CLAIM   = 24'd60928;
    localparam logic [23:0] PGN_PRODUCT = 24'd126996;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_NAME     = 3'd0,
        CFG_START_ADDR   = 3'd1,
        CFG_HOLD_IDLE    = 3'd2,
        CFG_RANDOM_DELAY = 3'd3,
        CFG_CLAIM_DELAY  = 3'd4
    } t_cfg_index;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_FRAME = 1'b1
    } t_command;

    typedef enum logic [3:0] {
        ST_IDLE          = 4'd0,
        ST_BACKOFF       = 4'd1,
        ST_SEND_CLAIM    = 4'd2,
        ST_WAIT_CONTEST  = 4'd3,
        ST_NEXT_ADDRESS  = 4'd4,
        ST_CLAIMED       = 4'd5,
        ST_CC_DELAY      = 4'd6,
        ST_CC_SEND       = 4'd7,
        ST_CC_WAIT       = 4'd8,
        ST_RECLAIM       = 4'd9
    } t_state;

    typedef struct packed {
        logic        command;
        logic [28:0] frame_id;
        logic [63:0] frame_data;
    } t_item;

    typedef struct packed {
        logic       send_claim;
        logic [7:0] claim_source;
        logic       address_claimed;
        logic       save_address;
        logic       send_product_info;
        logic [7:0] current_address;
        logic [3:0] protocol_state;
    } t_result;

    // Saved addresses at or above the last claimable one start over at 1.
    function automatic logic [7:0] clamp_start(input logic [7:0] addr);
        clamp_start = (addr >= LAST_ADDRESS) ? 8'd1 : addr;
    endfunction

endpackage

### src/acf_in_stage.sv
module acf_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_command,
    input  logic [28:0]    i_frame_id,
    input  logic [63:0]    i_frame_data,
    input  logic           i_take,
    output logic           o_item_valid,
    output acf_pkg::t_item o_item
);
    import acf_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The held beat leaves when the engine takes it; a new one may enter
    // in that same cycle.
    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item.command    <= i_command;
            r_item.frame_id   <= i_frame_id;
            r_item.frame_data <= i_frame_data;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

### src/acf_engine.sv
module acf_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [acf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [acf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_fire,
    input  acf_pkg::t_item                   i_item,
    output acf_pkg::t_result                 o_result
);
    import acf_pkg::*;

    logic [63:0] r_own_name;
    logic        r_hold_idle;
    logic [7:0]  r_random_delay;
    logic [7:0]  r_claim_delay;

    t_state      r_state, n_state;
    logic [7:0]  r_trial, n_trial;
    logic [7:0]  r_saved, n_saved;
    logic [7:0]  r_delay, n_delay;
    logic        r_done, n_done;
    logic [63:0] r_peer, n_peer;
    logic        r_req, n_req;

    logic [7:0]  tick_delay;
    logic        tick_done;
    logic        peer_present;
    logic        peer_lower;
    logic [7:0]  src_addr;
    logic [7:0]  dst_addr;
    logic [23:0] pgn;
    logic        is_claim;
    logic        is_request;
    logic        cfg_reload;
    t_result     res;

    function automatic logic [7:0] delay_load(input logic [7:0] ticks);
        delay_load = (ticks == 8'd0) ? 8'd1 : ticks;
    endfunction

    assign peer_present = (r_peer != 64'd0);
    assign peer_lower   = (r_peer < r_own_name);
    assign src_addr     = i_item.frame_id[7:0];
    assign dst_addr     = i_item.frame_id[15:8];
    assign pgn          = i_item.frame_data[23:0];
    assign is_claim     = (i_item.frame_id[28:8] == CLAIM_MATCH[28:8]);
    assign is_request   = (i_item.frame_id[28:16] == REQUEST_MATCH[28:16]);
    assign cfg_reload   = i_cfg_we && (i_cfg_index == CFG_START_ADDR) && (r_state == ST_IDLE);

    // The countdown of a tick happens before the state machine looks at it.
    always_comb begin
        tick_delay = r_delay;
        tick_done  = r_done;
        if (!r_done && (r_delay != 8'd0)) begin
            tick_delay = r_delay - 8'd1;
            tick_done  = (tick_delay == 8'd0);
        end
    end

    always_comb begin
        n_state = r_state;
        n_trial = r_trial;
        n_saved = r_saved;
        n_delay = r_delay;
        n_done  = r_done;
        n_peer  = r_peer;
        n_req   = r_req;
        res     = '0;
        if (i_fire && (i_item.command == CMD_TICK)) begin
            n_delay = tick_delay;
            n_done  = tick_done;
            case (r_state)
                ST_IDLE: begin
                    if (!r_hold_idle) begin
                        n_delay = delay_load(r_random_delay);
                        n_done  = 1'b0;
                        n_state = ST_BACKOFF;
                    end
                end
                ST_BACKOFF: begin
                    if (tick_done) n_state = ST_SEND_CLAIM;
                end
                ST_SEND_CLAIM: begin
                    res.send_claim   = 1'b1;
                    res.claim_source = r_trial;
                    n_delay = delay_load(r_claim_delay);
                    n_done  = 1'b0;
                    n_state = ST_WAIT_CONTEST;
                end
                ST_WAIT_CONTEST: begin
                    if (peer_present) begin
                        n_peer  = 64'd0;
                        n_state = peer_lower ? ST_NEXT_ADDRESS : ST_SEND_CLAIM;
                    end else if (tick_done) begin
                        n_state = ST_CLAIMED;
                        res.address_claimed = 1'b1;
                        if (r_trial != r_saved) begin
                            n_saved = r_trial;
                            res.save_address = 1'b1;
                        end
                    end
                end
                ST_NEXT_ADDRESS: begin
                    if (r_trial < LAST_ADDRESS) begin
                        n_trial = r_trial + 8'd1;
                        n_state = ST_SEND_CLAIM;
                    end else begin
                        n_delay = delay_load(r_random_delay);
                        n_done  = 1'b0;
                        n_state = ST_CC_DELAY;
                    end
                end
                ST_CLAIMED: begin
                    if (peer_present) begin
                        n_peer  = 64'd0;
                        n_state = peer_lower ? ST_NEXT_ADDRESS : ST_RECLAIM;
                    end else if (r_req) begin
                        n_req   = 1'b0;
                        n_state = ST_RECLAIM;
                    end
                end
                ST_CC_DELAY: begin
                    if (tick_done) n_state = ST_CC_SEND;
                end
                ST_CC_SEND: begin
                    res.send_claim   = 1'b1;
                    res.claim_source = CANNOT_CLAIM_ADDRESS;
                    n_state = ST_CC_WAIT;
                end
                ST_CC_WAIT: begin
                    if (r_req) begin
                        n_req   = 1'b0;
                        n_delay = delay_load(r_random_delay);
                        n_done  = 1'b0;
                        n_state = ST_CC_DELAY;
                    end
                end
                ST_RECLAIM: begin
                    res.send_claim      = 1'b1;
                    res.claim_source    = r_trial;
                    res.address_claimed = 1'b1;
                    n_state = ST_CLAIMED;
                    if (r_trial != r_saved) begin
                        n_saved = r_trial;
                        res.save_address = 1'b1;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end else if (i_fire) begin
            if (is_claim && (src_addr == r_trial)) n_peer = i_item.frame_data;
            if (is_request && ((dst_addr == r_trial) || (dst_addr == GLOBAL_ADDRESS))) begin
                if (pgn == PGN_CLAIM) n_req = 1'b1;
                if (pgn == PGN_PRODUCT) res.send_product_info = 1'b1;
            end
        end
        res.current_address = n_trial;
        res.protocol_state  = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_name     <= 64'd0;
            r_hold_idle    <= 1'b0;
            r_random_delay <= 8'd2;
            r_claim_delay  <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OWN_NAME:     r_own_name     <= i_cfg_data;
                CFG_START_ADDR: begin
                    // The start address only reloads the address registers
                    // below, and only while idle; nothing else reads it.
                end
                CFG_HOLD_IDLE:    r_hold_idle    <= i_cfg_data[0];
                CFG_RANDOM_DELAY: r_random_delay <= i_cfg_data[7:0];
                CFG_CLAIM_DELAY:  r_claim_delay  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_trial <= clamp_start(8'd1);
            r_saved <= 8'd1;
            r_delay <= 8'd0;
            r_done  <= 1'b0;
            r_peer  <= 64'd0;
            r_req   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_delay <= n_delay;
            r_done  <= n_done;
            r_peer  <= n_peer;
            r_req   <= n_req;
            if (cfg_reload) begin
                r_trial <= clamp_start(i_cfg_data[7:0]);
                r_saved <= i_cfg_data[7:0];
            end else begin
                r_trial <= n_trial;
                r_saved <= n_saved;
            end
        end
    end

    assign o_result = res;

endmodule

### src/can_address_claim_fsm.sv
// An accepted input beat passes the input register, then the state step into the result
// register. Throughput: one beat per cycle while i_stall is low; the single state step
// per beat is the only loop.
// Reset (i_rst_n, synchronous, active low) clears the handshake flags, returns the
// state machine to idle and loads the configuration registers with their defaults.
module can_address_claim_fsm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [acf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [acf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_command,
    input  logic [28:0]                    i_frame_id,
    input  logic [63:0]                    i_frame_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_send_claim,
    output logic [7:0]                     o_claim_source,
    output logic                           o_address_claimed,
    output logic                           o_save_address,
    output logic                           o_send_product_info,
    output logic [7:0]                     o_current_address,
    output logic [3:0]                     o_protocol_state
);
    import acf_pkg::*;

    logic    item_valid;
    t_item   item;
    logic    fire;
    t_result step_result;
    logic    r_out_valid;
    t_result r_out;

    // A held beat is stepped whenever the result register is empty or its
    // beat is being taken this cycle, so the two sides never wait on each
    // other for more than the downstream stall itself.
    assign fire = item_valid && (!r_out_valid || !i_stall);

    acf_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_frame_id   (i_frame_id),
        .i_frame_data (i_frame_data),
        .i_take       (fire),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    // The engine holds the configuration registers and the claim state,
    // and produces the full result of one beat combinationally.
    acf_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (item),
        .o_result    (step_result)
    );

    // Result register: a new result replaces the old one only when the old
    // one is gone or leaves in this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= step_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_send_claim        = r_out.send_claim;
    assign o_claim_source      = r_out.claim_source;
    assign o_address_claimed   = r_out.address_claimed;
    assign o_save_address      = r_out.save_address;
    assign o_send_product_info = r_out.send_product_info;
    assign o_current_address   = r_out.current_address;
    assign o_protocol_state    = r_out.protocol_state;

endmodule

### src/acf_checker.sv
module acf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_send_claim,
    input logic [7:0] o_claim_source,
    input logic       o_address_claimed,
    input logic       o_save_address,
    input logic [3:0] o_protocol_state
);
    import acf_pkg::*;

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_claim_source)
            && $stable(o_protocol_state))
        else $error("stalled result beat changed");

    // No claim means no claim source.
    a_src_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_send_claim |-> o_claim_source == 8'd0)
        else $error("claim source set without a claim");

    // An address save only comes with a confirmation, which lands in the claimed state.
    a_save: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_save_address |-> o_address_claimed
            && o_protocol_state == ST_CLAIMED)
        else $error("address save outside a confirmation");

    // The cannot-claim frame always goes out from the reserved address.
    a_cannot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_claim && o_protocol_state == ST_CC_WAIT
            |-> o_claim_source == CANNOT_CLAIM_ADDRESS)
        else $error("cannot-claim sent from wrong address");

endmodule

bind can_address_claim_fsm acf_checker u_acf_checker (.*);

### dv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the address claim engine. Every accepted input beat
// is run through a local model of the claim procedure, and the predicted
// outcome is queued. Each result beat the block hands out is compared field
// by field with the oldest queued outcome.
module tb;

    import acf_pkg::*;

    localparam logic [63:0] NAME_MAX = '1;

    // The block answers once a beat has passed its input and result registers. The
    // quiet stretch after the last outcome leaves a margin before any register write.
    localparam int DRAIN_CYCLES = 4;

    // The longest quiet stretch in a correct run is a register update or a run of
    // random sender gaps or receiver stalls. This limit is many times the worst.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        CONTEST_NONE,
        CONTEST_LOST,
        CONTEST_WON
    } t_contest;

    // All inputs start at known values. Reset is held from time zero.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_command = 1'b0;
    logic [28:0]           i_frame_id = '0;
    logic [63:0]           i_frame_data = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_send_claim;
    logic [7:0]            o_claim_source;
    logic                  o_address_claimed;
    logic                  o_save_address;
    logic                  o_send_product_info;
    logic [7:0]            o_current_address;
    logic [3:0]            o_protocol_state;

    can_address_claim_fsm u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_command           (i_command),
        .i_frame_id          (i_frame_id),
        .i_frame_data        (i_frame_data),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_send_claim        (o_send_claim),
        .o_claim_source      (o_claim_source),
        .o_address_claimed   (o_address_claimed),
        .o_save_address      (o_save_address),
        .o_send_product_info (o_send_product_info),
        .o_current_address   (o_current_address),
        .o_protocol_state    (o_protocol_state)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Local copy of the claim engine: register copies and machine state.
    // ------------------------------------------------------------------
    logic [63:0] reg_own_name;
    logic [7:0]  reg_start;
    logic        reg_hold;
    logic [7:0]  reg_rand_delay;
    logic [7:0]  reg_claim_delay;

    t_state      eng_state;
    logic [7:0]  eng_trial;
    logic [7:0]  eng_saved;
    logic [7:0]  eng_count;
    logic        eng_done;
    logic [63:0] eng_peer;
    logic        eng_req;

    // Outcomes predicted for accepted beats, oldest first.
    t_result claim_outcomes[$];

    // Knobs that the test tasks turn; the stall process and the sender read them.
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    bit drain_next = 1'b0;

    // Bookkeeping for the checker and the closing summary.
    int          mismatches = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          claims_seen = 0;
    int          saves_seen = 0;
    int          products_seen = 0;
    logic [9:0]  states_seen = '0;
    t_result     want;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic load_start_address();
        eng_saved = reg_start;
        eng_trial = (reg_start >= LAST_ADDRESS) ? 8'd1 : reg_start;
    endtask

    task automatic reset_model();
        reg_own_name    = '0;
        reg_start       = 8'd1;
        reg_hold        = 1'b0;
        reg_rand_delay  = 8'd2;
        reg_claim_delay = 8'd3;
        eng_state       = ST_IDLE;
        load_start_address();
        eng_count       = '0;
        eng_done        = 1'b0;
        eng_peer        = '0;
        eng_req         = 1'b0;
    endtask

    task automatic apply_register(input t_cfg_index idx, input logic [63:0] value);
        case (idx)
            CFG_OWN_NAME:     reg_own_name = value;
            CFG_START_ADDR: begin
                // A new saved address only takes effect while still idle.
                reg_start = value[7:0];
                if (eng_state == ST_IDLE) load_start_address();
            end
            CFG_HOLD_IDLE:    reg_hold = value[0];
            CFG_RANDOM_DELAY: reg_rand_delay = value[7:0];
            CFG_CLAIM_DELAY:  reg_claim_delay = value[7:0];
            default: ;
        endcase
    endtask

    // A delay of zero ticks behaves as one tick.
    task automatic arm_delay(input logic [7:0] ticks);
        eng_count = (ticks == 8'd0) ? 8'd1 : ticks;
        eng_done  = 1'b0;
    endtask

    // Uses up the recorded peer name. A zero name means nobody contended, and
    // an equal name is not lower, so we win.
    task automatic resolve_contest(output t_contest c);
        c = CONTEST_NONE;
        if (eng_peer != '0) begin
            c = (eng_peer < reg_own_name) ? CONTEST_LOST : CONTEST_WON;
            eng_peer = '0;
        end
    endtask

    task automatic confirm_address(inout t_result r);
        r.address_claimed = 1'b1;
        if (eng_trial != eng_saved) begin
            eng_saved = eng_trial;
            r.save_address = 1'b1;
        end
    endtask

    // One step of the engine: a tick counts down and advances the machine,
    // a frame only records a claim or a request.
    task automatic step_claim_engine(input t_item it, output t_result r);
        t_contest   c;
        logic [7:0] src;
        logic [7:0] dst;
        r = '0;
        if (it.command == CMD_TICK) begin
            if (!eng_done && eng_count != 8'd0) begin
                eng_count = eng_count - 8'd1;
                if (eng_count == 8'd0) eng_done = 1'b1;
            end
            case (eng_state)
                ST_IDLE: begin
                    if (!reg_hold) begin
                        arm_delay(reg_rand_delay);
                        eng_state = ST_BACKOFF;
                    end
                end
                ST_BACKOFF: begin
                    if (eng_done) eng_state = ST_SEND_CLAIM;
                end
                ST_SEND_CLAIM: begin
                    r.send_claim   = 1'b1;
                    r.claim_source = eng_trial;
                    arm_delay(reg_claim_delay);
                    eng_state = ST_WAIT_CONTEST;
                end
                ST_WAIT_CONTEST: begin
                    resolve_contest(c);
                    if (c == CONTEST_LOST) begin
                        eng_state = ST_NEXT_ADDRESS;
                    end else if (c == CONTEST_WON) begin
                        eng_state = ST_SEND_CLAIM;
                    end else if (eng_done) begin
                        eng_state = ST_CLAIMED;
                        confirm_address(r);
                    end
                end
                ST_NEXT_ADDRESS: begin
                    if (eng_trial < LAST_ADDRESS) begin
                        eng_trial = eng_trial + 8'd1;
                        eng_state = ST_SEND_CLAIM;
                    end else begin
                        arm_delay(reg_rand_delay);
                        eng_state = ST_CC_DELAY;
                    end
                end
                ST_CLAIMED: begin
                    resolve_contest(c);
                    if (c == CONTEST_LOST) begin
                        eng_state = ST_NEXT_ADDRESS;
                    end else if (c == CONTEST_WON) begin
                        eng_state = ST_RECLAIM;
                    end else if (eng_req) begin
                        eng_req   = 1'b0;
                        eng_state = ST_RECLAIM;
                    end
                end
                ST_CC_DELAY: begin
                    if (eng_done) eng_state = ST_CC_SEND;
                end
                ST_CC_SEND: begin
                    // Cannot-claim goes out from the null address, while the
                    // reported address stays at the last one tried.
                    r.send_claim   = 1'b1;
                    r.claim_source = CANNOT_CLAIM_ADDRESS;
                    eng_state = ST_CC_WAIT;
                end
                ST_CC_WAIT: begin
                    if (eng_req) begin
                        eng_req = 1'b0;
                        arm_delay(reg_rand_delay);
                        eng_state = ST_CC_DELAY;
                    end
                end
                ST_RECLAIM: begin
                    r.send_claim   = 1'b1;
                    r.claim_source = eng_trial;
                    eng_state = ST_CLAIMED;
                    confirm_address(r);
                end
                default: eng_state = ST_IDLE;
            endcase
        end else begin
            src = it.frame_id[7:0];
            dst = it.frame_id[15:8];
            if (it.frame_id[28:8] == CLAIM_MATCH[28:8] && src == eng_trial) begin
                eng_peer = it.frame_data;
            end
            if (it.frame_id[28:16] == REQUEST_MATCH[28:16] &&
                (dst == eng_trial || dst == GLOBAL_ADDRESS)) begin
                if (it.frame_data[23:0] == PGN_CLAIM) eng_req = 1'b1;
                if (it.frame_data[23:0] == PGN_PRODUCT) r.send_product_info = 1'b1;
            end
        end
        r.current_address = eng_trial;
        r.protocol_state  = eng_state;
    endtask

    // ------------------------------------------------------------------
    // Beat builders.
    // ------------------------------------------------------------------
    // The frame fields of a tick are don't-care, so they carry random bits.
    function automatic t_item tick_item();
        t_item it;
        it.command    = CMD_TICK;
        it.frame_id   = 29'($urandom);
        it.frame_data = rand64();
        return it;
    endfunction

    function automatic t_item frame_item(input logic [28:0] id, input logic [63:0] data);
        t_item it;
        it.command    = CMD_FRAME;
        it.frame_id   = id;
        it.frame_data = data;
        return it;
    endfunction

    function automatic t_item claim_item(input logic [7:0] src, input logic [63:0] name);
        return frame_item({CLAIM_MATCH[28:8], src}, name);
    endfunction

    // The requester's own address and the upper data bytes are random.
    function automatic t_item request_item(input logic [7:0] dst, input logic [23:0] pgn);
        logic [63:0] data;
        data = rand64();
        return frame_item({REQUEST_MATCH[28:16], dst, 8'($urandom)}, {data[63:24], pgn});
    endfunction

    // A name for a claim against our trial address: lower (we lose) with the
    // given chance, otherwise equal, zero or higher.
    function automatic logic [63:0] contender_name(input int lose_pct);
        logic [63:0] r;
        int          pick;
        r    = rand64();
        pick = $urandom_range(99);
        if (pick < lose_pct && reg_own_name > 64'd1) return 64'd1 + (r % (reg_own_name - 64'd1));
        else if (pick < lose_pct + 15) return reg_own_name;
        else if (pick < lose_pct + 25) return '0;
        else if (reg_own_name == NAME_MAX) return NAME_MAX;
        else return reg_own_name + 64'd1 + (r % (NAME_MAX - reg_own_name));
    endfunction

    // Mostly ticks, claims and requests aimed at our address, the rest noise.
    function automatic t_item random_item(input int lose_pct);
        int         pick;
        logic [7:0] dst;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 60) dst = eng_trial;
        else if ($urandom_range(1) == 1) dst = GLOBAL_ADDRESS;
        else dst = 8'($urandom);
        if (pick < 45) return tick_item();
        else if (pick < 62) return claim_item(eng_trial, contender_name(lose_pct));
        else if (pick < 67) return claim_item(8'($urandom), rand64());
        else if (pick < 76) return request_item(dst, PGN_CLAIM);
        else if (pick < 84) return request_item(dst, PGN_PRODUCT);
        else if (pick < 89) return request_item(dst, 24'($urandom));
        else return frame_item(29'($urandom), rand64());
    endfunction

    // ------------------------------------------------------------------
    // Driving.
    // ------------------------------------------------------------------
    // Sends one beat and predicts its outcome at the edge where it is taken.
    // Valid stays high when the next beat follows without a gap, so a raised
    // valid is never lowered and raised again within one time step.
    task automatic send_beat(input t_item it);
        t_result r;
        if (drain_next || $urandom_range(99) == 0) begin
            // Hold off until the block has handed out every pending outcome.
            drain_next = 1'b0;
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (claim_outcomes.size() != 0) @(posedge i_clk);
        end
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= it.command;
        i_frame_id   <= it.frame_id;
        i_frame_data <= it.frame_data;
        do @(posedge i_clk); while (o_stall);
        step_claim_engine(it, r);
        claim_outcomes.push_back(r);
        beats_in++;
    endtask

    // Brings the block to rest: no beat offered, every outcome delivered and
    // a further drain wait for anything still in flight.
    task automatic settle_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (claim_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write, after which the enable goes low again.
    task automatic cfg_write(input t_cfg_index idx, input logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        apply_register(idx, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Narrow registers get random bits above their width; only the low bits count.
    task automatic write_all_registers(input logic [63:0] own, input logic [7:0] start,
                                       input logic hold, input logic [7:0] rdelay,
                                       input logic [7:0] cdelay);
        logic [63:0] junk;
        junk = rand64();
        cfg_write(CFG_OWN_NAME, own);
        cfg_write(CFG_START_ADDR, {junk[63:8], start});
        cfg_write(CFG_HOLD_IDLE, {junk[63:1], hold});
        cfg_write(CFG_RANDOM_DELAY, {junk[63:8], rdelay});
        cfg_write(CFG_CLAIM_DELAY, {junk[63:8], cdelay});
    endtask

    task automatic run_random_phase(input int n_items, input logic [63:0] own,
                                    input logic hold, input logic [7:0] rdelay,
                                    input logic [7:0] cdelay, input int sidle,
                                    input int rstall, input int lose_pct);
        settle_block();
        write_all_registers(own, 8'($urandom), hold, rdelay, cdelay);
        sender_idle_pct = sidle;
        recv_stall_pct  = rstall;
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) drain_next = 1'b1;
            send_beat(random_item(lose_pct));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    // While held in idle: the saved address is clamped or reloaded on every
    // write, zero delays are set up, and requests are still recognized.
    task automatic test_idle_and_start_address();
        settle_block();
        cfg_write(CFG_HOLD_IDLE, 64'd1);
        cfg_write(CFG_OWN_NAME, NAME_MAX);
        cfg_write(CFG_RANDOM_DELAY, 64'd0);
        cfg_write(CFG_CLAIM_DELAY, 64'd0);
        cfg_write(CFG_START_ADDR, 64'd255);
        send_beat(tick_item());
        send_beat(request_item(GLOBAL_ADDRESS, PGN_PRODUCT));
        settle_block();
        cfg_write(CFG_START_ADDR, 64'd0);
        send_beat(tick_item());
        // This claim request stays pending until the machine reaches claimed.
        send_beat(request_item(8'd0, PGN_CLAIM));
        settle_block();
        cfg_write(CFG_START_ADDR, 64'd170);
        cfg_write(CFG_HOLD_IDLE, 64'd0);
    endtask

    // Back-off, claim, confirm, then the pending request forces a re-claim.
    task automatic test_claim_and_confirm();
        repeat (6) send_beat(tick_item());
    endtask

    // Zero, equal, foreign and lower names, ending with a move to the next
    // address and an address save, then a product request and two noise frames.
    task automatic test_contention();
        send_beat(claim_item(eng_trial, 64'd0));
        send_beat(tick_item());
        send_beat(claim_item(eng_trial, reg_own_name));
        send_beat(tick_item());
        send_beat(tick_item());
        send_beat(claim_item(eng_trial + 8'd1, 64'd1));
        send_beat(claim_item(eng_trial, 64'd1));
        repeat (4) send_beat(tick_item());
        send_beat(request_item(eng_trial, PGN_PRODUCT));
        send_beat(frame_item('1, NAME_MAX));
        send_beat(frame_item('0, '0));
    endtask

    // Four phases of random traffic, one per mix of sender gaps and receiver
    // stalls; delays hit both extremes; own names never lose, lose often or vary.
    task automatic test_random_traffic();
        run_random_phase(280, rand64(), 1'b0, 8'($urandom_range(1, 4)),
                         8'($urandom_range(1, 4)), 0, 0, 15);
        run_random_phase(280, 64'd0, 1'b1, 8'd255, 8'd255, 55, 0, 0);
        run_random_phase(280, NAME_MAX, 1'b0, 8'd0, 8'd0, 0, 55, 10);
        run_random_phase(280, rand64(), 1'b0, 8'($urandom), 8'($urandom_range(1, 8)),
                         7, 7, 30);
    endtask

    // Lose every contest until no address is left, then exercise the
    // cannot-claim loop: requests are matched against the last address tried.
    // Starting high keeps the walk to the last address short.
    task automatic test_cannot_claim();
        int guard;
        settle_block();
        write_all_registers(NAME_MAX, 8'd200, 1'b0, 8'd2, 8'd1);
        sender_idle_pct = 7;
        recv_stall_pct  = 7;
        guard = 0;
        while (eng_state != ST_CC_WAIT && guard < 2000) begin
            if (eng_peer == '0 && (eng_state == ST_SEND_CLAIM ||
                eng_state == ST_WAIT_CONTEST || eng_state == ST_CLAIMED ||
                eng_state == ST_RECLAIM)) begin
                send_beat(claim_item(eng_trial, 64'd1));
            end else begin
                send_beat(tick_item());
            end
            guard++;
        end
        send_beat(request_item(eng_trial, PGN_CLAIM));
        repeat (5) send_beat(tick_item());
        send_beat(request_item(eng_trial, PGN_PRODUCT));
        send_beat(claim_item(eng_trial, 64'd5));
        send_beat(request_item(GLOBAL_ADDRESS, PGN_CLAIM));
        repeat (5) send_beat(tick_item());
    endtask

    task automatic test_random_after_exhaustion();
        run_random_phase(150, rand64(), 1'b0, 8'($urandom_range(1, 3)), 8'd1, 55, 55, 40);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls and the outcome checker.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        mismatches++;
        if (mismatches <= 200) begin
            $display("MISMATCH at result beat %0d, %s: got %0h, predicted %0h",
                     beats_out, what, got, exp_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            beats_out++;
            if (claim_outcomes.size() == 0) begin
                flag_mismatch("result beat with no outcome pending", '0, '0);
            end else begin
                want = claim_outcomes.pop_front();
                if (o_send_claim !== want.send_claim)
                    flag_mismatch("send_claim", o_send_claim, want.send_claim);
                if (o_claim_source !== want.claim_source)
                    flag_mismatch("claim_source", o_claim_source, want.claim_source);
                if (o_address_claimed !== want.address_claimed)
                    flag_mismatch("address_claimed", o_address_claimed, want.address_claimed);
                if (o_save_address !== want.save_address)
                    flag_mismatch("save_address", o_save_address, want.save_address);
                if (o_send_product_info !== want.send_product_info)
                    flag_mismatch("send_product_info", o_send_product_info,
                                  want.send_product_info);
                if (o_current_address !== want.current_address)
                    flag_mismatch("current_address", o_current_address, want.current_address);
                if (o_protocol_state !== want.protocol_state)
                    flag_mismatch("protocol_state", o_protocol_state, want.protocol_state);
                claims_seen   += want.send_claim;
                saves_seen    += want.save_address;
                products_seen += want.send_product_info;
                states_seen[want.protocol_state] = 1'b1;
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved a beat for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("Watchdog: no beat moved in %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_and_start_address();
        test_claim_and_confirm();
        test_contention();
        test_random_traffic();
        test_cannot_claim();
        test_random_after_exhaustion();

        // Let every outstanding outcome come out before judging the run.
        settle_block();

        $display("Covered %0d input beats and %0d result beats: %0d claims, %0d saves,",
                 beats_in, beats_out, claims_seen, saves_seen);
        $display("%0d product requests; protocol states reached (9..0): %b",
                 products_seen, states_seen);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
